// ===== rtl/mme_pkg.sv =====
// Shared types, codes and sizes for the matrix multiply engine.
`default_nettype none
package mme_pkg;

  localparam int DEF_MAX_DIM = 8;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = 35;
  localparam int CFG_IDX_W   = 2;
  localparam int MODE_W      = 2;
  localparam int CMD_DEPTH   = 2;
  localparam int OUT_DEPTH   = 4;

  localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_WR_A,
    CMD_WR_B,
    CMD_COMPUTE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                  op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_dim;
    logic [DIM_W-1:0] cols_b;
  } dims_t;

endpackage
`default_nettype wire

// ===== rtl/mme_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/mme_fifo.sv =====
// Small register-based queue, used for commands and for finished results.
`default_nettype none
module mme_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o,
  output logic                  full_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mme_front.sv =====
// Front end: take requests, drop those that do nothing, hand commands on.
`default_nettype none
module mme_front
  import mme_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [MODE_W-1:0]        mode_i,
  input  wire logic [IDX_W-1:0]         elem_row_i,
  input  wire logic [IDX_W-1:0]         elem_col_i,
  input  wire logic signed [ELEM_W-1:0] elem_value_i,
  output logic                          cmd_push_o,
  output cmd_t                          cmd_o,
  input  wire logic                     cmd_full_i
);

  logic cmd_valid_q, cmd_valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept, in_range, keep;

  assign in_stall_o = cmd_valid_q && cmd_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_push_o = cmd_valid_q && !cmd_full_i;
  assign cmd_o      = cmd_q;

  assign in_range = (DIM_W'(elem_row_i) < DIM_W'(MAX_DIM))
                 && (DIM_W'(elem_col_i) < DIM_W'(MAX_DIM));

  // Classify: out-of-range writes and the unused mode are dropped here.
  always_comb begin
    cmd_d       = cmd_q;
    keep        = 1'b0;
    cmd_d.row   = elem_row_i;
    cmd_d.col   = elem_col_i;
    cmd_d.value = elem_value_i;
    unique case (mode_i)
      MODE_WR_A: begin
        cmd_d.op = CMD_WR_A;
        keep     = in_range;
      end
      MODE_WR_B: begin
        cmd_d.op = CMD_WR_B;
        keep     = in_range;
      end
      MODE_COMPUTE: begin
        cmd_d.op = CMD_COMPUTE;
        keep     = 1'b1;
      end
      default: begin
        cmd_d.op = CMD_COMPUTE;
        keep     = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (cmd_push_o) begin
      cmd_valid_d = 1'b0;
    end
    if (accept) begin
      cmd_valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mme_back.sv =====
// Back end: store writes and the multiply-accumulate sequencer.
`default_nettype none
module mme_back
  import mme_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_pop_o,
  input  wire dims_t dims_i,
  output logic       res_push_o,
  output res_t       res_o,
  input  wire logic  res_pop_i
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FULL_W = 2 * IDX_W + 1;
  localparam int PEND_W = $clog2(OUT_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  function automatic logic [ADDR_W-1:0] addr_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    logic [FULL_W-1:0] full;
    full = FULL_W'(r) * FULL_W'(MAX_DIM) + FULL_W'(c);
    return full[ADDR_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] reg_val);
    logic [DIM_W-1:0] res;
    if (reg_val == '0) begin
      res = DIM_W'(1);
    end else if (reg_val > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

  logic                state_q, state_d;
  logic [IDX_W-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic [DIM_W-1:0]    nr_q, nr_d, nk_q, nk_d, nc_q, nc_d;
  logic [PEND_W-1:0]   pend_q, pend_d;
  logic                start, issue, elem_start, last_k, last_i, last_j;
  logic                wr_a, wr_b;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ELEM_W-1:0]   a_rdata, b_rdata;

  // Stage one: tags aligned with the RAM read data.
  logic                s1_valid_q, s1_first_q, s1_lastk_q, s1_lastel_q;
  logic [IDX_W-1:0]    s1_i_q, s1_j_q;
  // Stage two: registered product.
  logic                s2_valid_q, s2_first_q, s2_lastk_q, s2_lastel_q;
  logic [IDX_W-1:0]    s2_i_q, s2_j_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign wr_a      = cmd_pop_o && (cmd_i.op == CMD_WR_A);
  assign wr_b      = cmd_pop_o && (cmd_i.op == CMD_WR_B);
  assign start     = cmd_pop_o && (cmd_i.op == CMD_COMPUTE);
  assign wr_addr   = addr_of(cmd_i.row, cmd_i.col);

  // Hold a new element back until the result queue has room reserved for it.
  assign issue      = (state_q == ST_RUN) && ((k_q != '0) || (pend_q < PEND_W'(OUT_DEPTH)));
  assign elem_start = issue && (k_q == '0);
  assign last_k     = ({1'b0, k_q} == nk_q - DIM_W'(1));
  assign last_i     = ({1'b0, i_q} == nr_q - DIM_W'(1));
  assign last_j     = ({1'b0, j_q} == nc_q - DIM_W'(1));

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk_i  (clk_i),
    .we_i   (wr_a),
    .waddr_i(wr_addr),
    .wdata_i(cmd_i.value),
    .raddr_i(addr_of(i_q, k_q)),
    .rdata_o(a_rdata)
  );

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk_i  (clk_i),
    .we_i   (wr_b),
    .waddr_i(wr_addr),
    .wdata_i(cmd_i.value),
    .raddr_i(addr_of(k_q, j_q)),
    .rdata_o(b_rdata)
  );

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    nr_d    = nr_q;
    nk_d    = nk_q;
    nc_d    = nc_q;
    if (start) begin
      state_d = ST_RUN;
      i_d     = '0;
      j_d     = '0;
      k_d     = '0;
      nr_d    = eff_dim(dims_i.rows_a);
      nk_d    = eff_dim(dims_i.inner_dim);
      nc_d    = eff_dim(dims_i.cols_b);
    end else if (issue) begin
      if (last_k) begin
        k_d = '0;
        if (last_j) begin
          j_d = '0;
          if (last_i) begin
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end else begin
        k_d = k_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (elem_start && !res_pop_i) begin
      pend_d = pend_q + PEND_W'(1);
    end else if (res_pop_i && !elem_start) begin
      pend_d = pend_q - PEND_W'(1);
    end
  end

  assign acc_d = s2_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  assign res_push_o  = s2_valid_q && s2_lastk_q;
  assign res_o.row   = s2_i_q;
  assign res_o.col   = s2_j_q;
  assign res_o.value = acc_d;
  assign res_o.last  = s2_lastel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      nr_q       <= DIM_W'(1);
      nk_q       <= DIM_W'(1);
      nc_q       <= DIM_W'(1);
      pend_q     <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      nr_q       <= nr_d;
      nk_q       <= nk_d;
      nc_q       <= nc_d;
      pend_q     <= pend_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q  <= (k_q == '0);
    s1_lastk_q  <= last_k;
    s1_lastel_q <= last_i && last_j;
    s1_i_q      <= i_q;
    s1_j_q      <= j_q;
    s2_first_q  <= s1_first_q;
    s2_lastk_q  <= s1_lastk_q;
    s2_lastel_q <= s1_lastel_q;
    s2_i_q      <= s1_i_q;
    s2_j_q      <= s1_j_q;
    prod_q      <= $signed(a_rdata) * $signed(b_rdata);
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/matrix_multiply_engine_top.sv =====
// Top level of the fixed-point matrix multiply engine.
`default_nettype none
// Fixed-point matrix multiply engine. Requests on the input channel either
// load one signed Q8.8 entry of matrix A (mode 0) or matrix B (mode 1), or
// ask for the product C = A * B (mode 2); mode 3 and loads whose row or
// column lies outside the stores are dropped without a result. A compute
// request sends every element of C in row-major order on the output
// channel, each the exact signed Q19.16 sum of its products, with last set
// on the final element. The dimension registers (rows_a, inner_dim, cols_b)
// are to be written by the user on the configuration port only while the
// block is idle; the block itself does not enforce it. A value of 0 acts
// as 1 and a value above MAX_DIM acts as MAX_DIM. Every store entry that a
// compute reads must have been loaded since reset; the stores have no
// clearing pass and are usable straight out of reset. A compute takes the
// products of each result element one after another on the single
// multiply-accumulate unit, through the RAM read, multiply and accumulate
// stages; results queue in a four-entry buffer and issue pauses only when
// that buffer is reserved in full. A command queue of two entries sits
// between the request decoder and the compute sequencer; it holds loads
// sent while a product is worked on, until it and the decoder are full.
module matrix_multiply_engine_top
  import mme_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [MODE_W-1:0]        mode_i,
  input  wire logic [IDX_W-1:0]         elem_row_i,
  input  wire logic [IDX_W-1:0]         elem_col_i,
  input  wire logic signed [ELEM_W-1:0] elem_value_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [IDX_W-1:0]              out_row_o,
  output logic [IDX_W-1:0]              out_col_o,
  output logic signed [ACC_W-1:0]       out_value_o,
  output logic                          last_o,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [DIM_W-1:0]         cfg_data_i
);

  dims_t dims_q, dims_d;
  logic  cfg_write;

  // Decoder to sequencer command path.
  logic  front_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t  front_cmd, queue_cmd;

  // Sequencer to output path.
  logic  res_push, res_full, res_empty, res_pop;
  res_t  back_res, head_res;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    dims_d = dims_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_ROWS_A:    dims_d.rows_a    = cfg_data_i;
        CFG_INNER_DIM: dims_d.inner_dim = cfg_data_i;
        CFG_COLS_B:    dims_d.cols_b    = cfg_data_i;
        default:       dims_d           = dims_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= '{rows_a: DIM_RESET, inner_dim: DIM_RESET, cols_b: DIM_RESET};
    end else begin
      dims_q <= dims_d;
    end
  end

  mme_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .elem_row_i  (elem_row_i),
    .elem_col_i  (elem_col_i),
    .elem_value_i(elem_value_i),
    .cmd_push_o  (front_push),
    .cmd_o       (front_cmd),
    .cmd_full_i  (cmd_full)
  );

  mme_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .pop_i  (cmd_pop),
    .data_o (queue_cmd),
    .empty_o(cmd_empty),
    .full_o (cmd_full)
  );

  mme_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (cmd_pop),
    .dims_i     (dims_q),
    .res_push_o (res_push),
    .res_o      (back_res),
    .res_pop_i  (res_pop)
  );

  // The sequencer reserves a slot before each element, so a push never
  // meets a full buffer.
  mme_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (back_res),
    .pop_i  (res_pop),
    .data_o (head_res),
    .empty_o(res_empty),
    .full_o (res_full)
  );

  assign out_valid_o = !res_empty;
  assign res_pop     = out_valid_o && !out_stall_i && !(res_full && 1'b0);
  assign out_row_o   = head_res.row;
  assign out_col_o   = head_res.col;
  assign out_value_o = head_res.value;
  assign last_o      = head_res.last;

endmodule
`default_nettype wire
